/* rtl/blst_pkg.sv */
`default_nettype none

package blst_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned STAT_W     = 2;

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
  localparam logic [OP_W-1:0] OP_TOP    = 3'd3;
  localparam logic [OP_W-1:0] OP_BOTTOM = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ST_INVALID   = 2'd3;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(DEPTH);

  // Per-cycle command broadcast to every cell of the stack
  typedef struct packed {
    logic push;   // shift stack down, top takes the new word
    logic pop;    // shift stack up
    logic load;   // copy stack into the read chain
    logic shift;  // move the read chain one cell toward the top
  } blst_ctrl_t;

endpackage

`default_nettype wire

/* rtl/blst_in_if.sv */
`default_nettype none

interface blst_in_if;
  logic                                        valid;
  logic                                        ready;
  logic [blst_pkg::OP_W-1:0]                   opcode;
  logic signed [blst_pkg::DATA_WIDTH-1:0]      push_value;
  logic [blst_pkg::POS_W-1:0]                  position;

  modport source (output valid, opcode, push_value, position, input ready);
  modport sink   (input valid, opcode, push_value, position, output ready);
endinterface

`default_nettype wire

/* rtl/blst_out_if.sv */
`default_nettype none

interface blst_out_if;
  logic                                        valid;
  logic                                        ready;
  logic signed [blst_pkg::DATA_WIDTH-1:0]      read_data;
  logic [blst_pkg::STAT_W-1:0]                 status;
  logic [blst_pkg::CNT_W-1:0]                  entry_count;
  logic                                        is_full;
  logic                                        is_empty;

  modport source (output valid, read_data, status, entry_count, is_full, is_empty,
                  input ready);
  modport sink   (input valid, read_data, status, entry_count, is_full, is_empty,
                  output ready);
endinterface

`default_nettype wire

/* rtl/blst_cell.sv */
`default_nettype none

module blst_cell (
  input  wire logic                            clk_i,
  input  wire blst_pkg::blst_ctrl_t            ctrl_i,
  input  wire logic [blst_pkg::DATA_WIDTH-1:0] up_data_i,
  input  wire logic [blst_pkg::DATA_WIDTH-1:0] down_data_i,
  input  wire logic [blst_pkg::DATA_WIDTH-1:0] rd_down_i,
  output logic [blst_pkg::DATA_WIDTH-1:0]      data_o,
  output logic [blst_pkg::DATA_WIDTH-1:0]      rd_o
);
  import blst_pkg::*;

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [DATA_WIDTH-1:0] rd_q, rd_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.push) begin
      data_d = up_data_i;
    end else if (ctrl_i.pop) begin
      data_d = down_data_i;
    end
  end

  always_comb begin
    rd_d = rd_q;
    if (ctrl_i.load) begin
      rd_d = data_q;
    end else if (ctrl_i.shift) begin
      rd_d = rd_down_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    rd_q   <= rd_d;
  end

  assign data_o = data_q;
  assign rd_o   = rd_q;

endmodule

`default_nettype wire

/* rtl/bounded_lifo_stack_top.sv */
`default_nettype none

// Bounded LIFO stack of signed words, built as a row of cells: cell 0 holds
// the top of stack, and push or pop moves every word one cell down or up in
// the same cycle. Push, pop, read top, any error, peek at position 1 and
// read bottom of one entry load the output register when taken. Other peeks
// and bottom reads use a second chain of read registers, loaded from the
// stack and moved one cell toward the top per cycle until the word reaches
// cell 0. A finished result sits in an output register; the next transaction
// is taken only when that register is empty or is read out in the same cycle.
// The user must write the capacity register (cfg_we_i/cfg_wdata_i) only while
// the block is idle; the block does not enforce it. Values above the stack
// depth act as the depth, and zero makes every push overflow.
module bounded_lifo_stack_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [blst_pkg::CFG_W-1:0]   cfg_wdata_i,
  blst_in_if.sink                           in_i,
  blst_out_if.source                        out_o
);
  import blst_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                  state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      remain_q, remain_d;
  logic [CFG_W-1:0]      cap_q;
  logic [CNT_W-1:0]      eff_cap;

  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] out_data_q;
  logic [STAT_W-1:0]     out_status_q;
  logic [CNT_W-1:0]      out_count_q;
  logic                  out_full_q, out_empty_q;

  logic                  out_free;
  logic                  accept;
  logic                  res_valid;
  logic [DATA_WIDTH-1:0] res_data;
  logic [STAT_W-1:0]     res_status;
  blst_ctrl_t            ctrl;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];

  assign eff_cap  = (CNT_W'(cap_q) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_q);
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign accept   = in_i.valid && in_i.ready;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    remain_d   = remain_q;
    res_valid  = 1'b0;
    res_data   = '1;
    res_status = ST_OK;
    ctrl       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_valid = 1'b1;
          unique case (in_i.opcode)
            OP_PUSH: begin
              if (count_q >= eff_cap) begin
                res_status = ST_OVERFLOW;
              end else begin
                ctrl.push = 1'b1;
                count_d   = count_q + CNT_W'(1);
                res_data  = '0;
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                res_status = ST_UNDERFLOW;
              end else begin
                ctrl.pop = 1'b1;
                count_d  = count_q - CNT_W'(1);
                res_data = cell_data[0];
              end
            end
            OP_PEEK: begin
              if ((in_i.position == '0) || (CNT_W'(in_i.position) > count_q)) begin
                res_status = ST_INVALID;
              end else if (in_i.position == POS_W'(1)) begin
                res_data = cell_data[0];
              end else begin
                // hold the result until the word reaches the head of the chain
                res_valid = 1'b0;
                ctrl.load = 1'b1;
                remain_d  = IDX_W'(in_i.position - POS_W'(1));
                state_d   = S_SCAN;
              end
            end
            OP_TOP: begin
              if (count_q == '0) begin
                res_status = ST_UNDERFLOW;
              end else begin
                res_data = cell_data[0];
              end
            end
            OP_BOTTOM: begin
              if (count_q == '0) begin
                res_status = ST_UNDERFLOW;
              end else if (count_q == CNT_W'(1)) begin
                res_data = cell_data[0];
              end else begin
                res_valid = 1'b0;
                ctrl.load = 1'b1;
                remain_d  = IDX_W'(count_q - CNT_W'(1));
                state_d   = S_SCAN;
              end
            end
            default: begin
              res_status = ST_INVALID;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (remain_q == '0) begin
          if (out_free) begin
            res_valid = 1'b1;
            res_data  = cell_rd[0];
            state_d   = S_IDLE;
          end
        end else begin
          ctrl.shift = 1'b1;
          remain_d   = remain_q - IDX_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = res_valid || (out_valid_q && !out_o.ready);

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] up_data;
    logic [DATA_WIDTH-1:0] down_data;
    logic [DATA_WIDTH-1:0] rd_down;

    if (k == 0) begin : g_head
      assign up_data = DATA_WIDTH'(in_i.push_value);
    end else begin : g_body
      assign up_data = cell_data[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign down_data = '0;
      assign rd_down   = '0;
    end else begin : g_link
      assign down_data = cell_data[k+1];
      assign rd_down   = cell_rd[k+1];
    end

    blst_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .up_data_i   (up_data),
      .down_data_i (down_data),
      .rd_down_i   (rd_down),
      .data_o      (cell_data[k]),
      .rd_o        (cell_rd[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q   <= res_data;
      out_status_q <= res_status;
      out_count_q  <= count_d;
      out_full_q   <= (count_d >= eff_cap);
      out_empty_q  <= (count_d == '0);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.read_data   = $signed(out_data_q);
  assign out_o.status      = out_status_q;
  assign out_o.entry_count = out_count_q;
  assign out_o.is_full     = out_full_q;
  assign out_o.is_empty    = out_empty_q;

endmodule

`default_nettype wire
